/* rtl/assert_macros.svh */
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed: label");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed: label");
`endif

/* rtl/ssw_pkg.sv */
// Package with shared types and constants of the shortest-word sorter.
package ssw_pkg;
    localparam int unsigned KEY_W      = 9;
    localparam int unsigned IDX_W      = 6;
    localparam logic [8:0]  EMPTY_KEY  = 9'd256;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;
    localparam logic [7:0]  NUL_CHAR   = 8'h00;

    // Request from the loader to the sorter.
    typedef struct packed {
        logic       start;
        logic [6:0] count;
    } sort_req_t;
endpackage

/* rtl/sort_strings_by_shortest_word_unit.sv */
// Top level of the shortest-word string sorter.
// Channel | Direction | tdata (low bit up)                  | tuser
// s_      | in        | byte_value[7:0]                     | present, string_end, set_end
// m_      | out       | string_index[5:0], sort_key[14:6]   | -, tlast = last_result
// Loading accepts one byte per cycle while the sorter is idle; set end starts the sort.
// The sort fills the order memory string by string, then pops ranges off the stack,
// scans keys at left and right, swaps and pushes. Emitting reads each order entry,
// then its key; s_tready stays low from set end to the last index.
// Reset is synchronous and clears the control state; memories are not cleared.
// A stalled result holds the sequencer until it is taken.
module sort_strings_by_shortest_word_unit #(
    parameter int MAX_STRINGS = 64,
    parameter int MAX_CHARS   = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic [2:0]  s_tuser,   // byte_present, string_end, set_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // string_index, sort_key, zero fill
    output logic        m_tlast    // last_result
);
    ssw_pkg::sort_req_t req;
    logic       busy, in_fire, key_we;
    logic [5:0] key_waddr, idx;
    logic [8:0] key_wdata, key;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tdata  = {1'b0, key, idx};

    ssw_loader #(.MAX_STRINGS(MAX_STRINGS), .MAX_CHARS(MAX_CHARS)) u_load (
        .aclk, .aresetn, .in_fire,
        .byte_value(s_tdata), .byte_present(s_tuser[0]),
        .string_end(s_tuser[1]), .set_end(s_tuser[2]),
        .key_we, .key_waddr, .key_wdata, .req
    );

    ssw_sorter u_sort (
        .aclk, .aresetn, .req, .key_we, .key_waddr, .key_wdata, .busy,
        .m_valid(m_tvalid), .m_ready(m_tready), .m_index(idx), .m_key(key),
        .m_last(m_tlast)
    );
endmodule

/* rtl/ssw_loader.sv */
// Loader: per-string word length tracking and key memory writes.
module ssw_loader #(
    parameter int MAX_STRINGS = 64,
    parameter int MAX_CHARS   = 255
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_fire,
    input  logic [7:0]             byte_value,
    input  logic                   byte_present,
    input  logic                   string_end,
    input  logic                   set_end,
    output logic                   key_we,
    output logic [5:0]             key_waddr,
    output logic [8:0]             key_wdata,
    output ssw_pkg::sort_req_t     req
);
    logic [6:0] count_reg;
    logic [7:0] word_reg;
    logic [8:0] short_reg;
    logic       pend_reg;
    logic [7:0] chars_reg;
    logic       take, is_space;
    logic [7:0] word_next;
    logic [8:0] short_next;
    logic       pend_next;
    logic [8:0] key_val;
    logic       close;

    // Character handling for the current item.
    always_comb begin
        take = byte_present && (byte_value != ssw_pkg::NUL_CHAR)
            && (chars_reg < 8'(MAX_CHARS));
        is_space = byte_value == ssw_pkg::SPACE_CHAR;
        word_next = word_reg;
        short_next = short_reg;
        pend_next = pend_reg;
        if (take) begin
            if (is_space) begin
                if ({1'b0, word_reg} < short_reg) short_next = {1'b0, word_reg};
                word_next = '0;
                pend_next = 1'b0;
            end else begin
                if (word_reg != 8'hFF) word_next = word_reg + 8'd1;
                pend_next = 1'b1;
            end
        end
        key_val = short_next;
        if (pend_next && ({1'b0, word_next} < short_next)) key_val = {1'b0, word_next};
        close = in_fire && (string_end || set_end);
    end

    assign key_we    = close && (count_reg < 7'(MAX_STRINGS));
    assign key_waddr = count_reg[5:0];
    assign key_wdata = key_val;
    assign req.start = in_fire && set_end;
    assign req.count = key_we ? count_reg + 7'd1 : count_reg;

    // Load state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && set_end)) begin
            count_reg <= '0;
            word_reg  <= '0;
            short_reg <= ssw_pkg::EMPTY_KEY;
            pend_reg  <= 1'b0;
            chars_reg <= '0;
        end else if (in_fire) begin
            if (close) begin
                if (key_we) count_reg <= count_reg + 7'd1;
                word_reg  <= '0;
                short_reg <= ssw_pkg::EMPTY_KEY;
                pend_reg  <= 1'b0;
                chars_reg <= '0;
            end else begin
                word_reg  <= word_next;
                short_reg <= short_next;
                pend_reg  <= pend_next;
                if (take) chars_reg <= chars_reg + 8'd1;
            end
        end
    end
endmodule

/* rtl/ssw_sorter.sv */
// Sorter: quicksort over the order memory with a range stack, then emit.
module ssw_sorter (
    input  logic               aclk,
    input  logic               aresetn,
    input  ssw_pkg::sort_req_t req,
    input  logic               key_we,
    input  logic [5:0]         key_waddr,
    input  logic [8:0]         key_wdata,
    output logic               busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_index,
    output logic [8:0]         m_key,
    output logic               m_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_POP, S_PIV, S_PIVK, S_LSCAN, S_LKEY, S_RSCAN, S_RKEY,
        S_SWAP, S_PUSH, S_EREAD, S_EKEY, S_EOUT
    } state_t;

    logic [8:0] key_mem [64];
    logic [5:0] ord_mem [64];
    logic [11:0] stk_mem [64];
    logic [8:0] key_rd;
    logic [5:0] ord_rd;
    logic [11:0] stk_rd;

    state_t     state_reg;
    logic [6:0] n_reg, stop_reg;
    logic [7:0] left_reg, right_reg, first_reg, last_reg;
    logic [8:0] pivot_reg;
    logic [5:0] ol_reg;
    logic [5:0] or_reg;
    logic [8:0] kl_reg;
    logic [6:0] k_reg;
    logic [5:0] ord_waddr, ord_wdata;
    logic       ord_we;
    logic [5:0] ord_raddr, key_raddr;
    logic       stk_we;
    logic [5:0] stk_waddr, stk_raddr;
    logic [11:0] stk_wdata;
    logic       swap_phase_reg;

    // Memories with registered reads.
    always_ff @(posedge aclk) begin
        if (key_we) key_mem[key_waddr] <= key_wdata;
        key_rd <= key_mem[key_raddr];
        if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
        ord_rd <= ord_mem[ord_raddr];
        if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
        stk_rd <= stk_mem[stk_raddr];
    end

    assign key_raddr = ord_rd;
    assign busy = state_reg != S_IDLE;

    // Address and write selection from the control state.
    always_comb begin
        ord_we = 1'b0;
        ord_waddr = k_reg[5:0];
        ord_wdata = k_reg[5:0];
        ord_raddr = left_reg[5:0];
        stk_we = 1'b0;
        stk_waddr = stop_reg[5:0];
        stk_wdata = '0;
        stk_raddr = 6'(stop_reg - 7'd1);
        case (state_reg)
            S_INIT: begin
                ord_we = 1'b1;
                // The whole range goes onto the stack with the last order entry.
                if (k_reg == n_reg - 7'd1) begin
                    stk_we = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = {6'd0, 6'(n_reg - 7'd1)};
                end
            end
            S_PIV: ord_raddr = 6'((first_reg + last_reg) >> 1);
            S_LSCAN: ord_raddr = left_reg[5:0];
            S_RSCAN: ord_raddr = right_reg[5:0];
            S_SWAP: begin
                ord_we = 1'b1;
                ord_waddr = swap_phase_reg ? right_reg[5:0] : left_reg[5:0];
                ord_wdata = swap_phase_reg ? ol_reg : or_reg;
                ord_raddr = right_reg[5:0];
            end
            S_PUSH: begin
                stk_we = 1'b1;
                if (swap_phase_reg) begin
                    stk_wdata = {first_reg[5:0], right_reg[5:0]};
                end else begin
                    stk_wdata = {left_reg[5:0], last_reg[5:0]};
                end
            end
            S_EREAD, S_EKEY, S_EOUT: ord_raddr = k_reg[5:0];
            default: ;
        endcase
    end

    // Control sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
            stop_reg  <= '0;
            swap_phase_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: if (req.start && req.count != 0) begin
                    n_reg <= req.count;
                    k_reg <= '0;
                    state_reg <= S_INIT;
                end
                S_INIT: begin
                    if (k_reg == n_reg - 7'd1) begin
                        stop_reg <= 7'(n_reg > 7'd1);
                        k_reg <= '0;
                        state_reg <= S_POP;
                    end else begin
                        k_reg <= k_reg + 7'd1;
                    end
                end
                S_POP: begin
                    if (stop_reg == 0) begin
                        k_reg <= '0;
                        state_reg <= S_EREAD;
                    end else begin
                        stop_reg <= stop_reg - 7'd1;
                        state_reg <= S_PIV;
                        swap_phase_reg <= 1'b1;
                    end
                end
                S_PIV: begin
                    if (swap_phase_reg) begin
                        first_reg <= {2'b0, stk_rd[11:6]};
                        last_reg  <= {2'b0, stk_rd[5:0]};
                        left_reg  <= {2'b0, stk_rd[11:6]};
                        right_reg <= {2'b0, stk_rd[5:0]};
                        swap_phase_reg <= 1'b0;
                    end else begin
                        state_reg <= S_PIVK;
                    end
                end
                S_PIVK: state_reg <= S_LKEY;
                S_LKEY: begin
                    pivot_reg <= key_rd;
                    state_reg <= S_LSCAN;
                end
                S_LSCAN: state_reg <= S_RSCAN;
                S_RSCAN: begin
                    if (!swap_phase_reg) begin
                        swap_phase_reg <= 1'b1;
                    end else begin
                        swap_phase_reg <= 1'b0;
                        state_reg <= S_RKEY;
                    end
                end
                S_RKEY: begin
                    // key of order[left] is in kl_reg, key of order[right] in key_rd.
                    if (left_reg < last_reg && kl_reg < pivot_reg) begin
                        left_reg <= left_reg + 8'd1;
                        state_reg <= S_LSCAN;
                    end else if (right_reg > first_reg && key_rd > pivot_reg) begin
                        right_reg <= right_reg - 8'd1;
                        state_reg <= S_LSCAN;
                    end else if (left_reg <= right_reg) begin
                        state_reg <= S_SWAP;
                        swap_phase_reg <= 1'b0;
                    end else begin
                        state_reg <= S_PUSH;
                        swap_phase_reg <= 1'b0;
                    end
                end
                S_SWAP: begin
                    if (!swap_phase_reg) begin
                        swap_phase_reg <= 1'b1;
                    end else begin
                        swap_phase_reg <= 1'b0;
                        left_reg  <= left_reg + 8'd1;
                        right_reg <= (right_reg == 0) ? 8'hFF : right_reg - 8'd1;
                        if ((left_reg + 8'd1) < ((right_reg == 0) ? 8'd0 : right_reg - 8'd1)
                            && right_reg != 0) begin
                            state_reg <= S_LSCAN;
                        end else begin
                            state_reg <= S_PUSH;
                        end
                    end
                end
                S_PUSH: begin
                    if (!swap_phase_reg) begin
                        if (left_reg < last_reg) stop_reg <= stop_reg + 7'd1;
                        swap_phase_reg <= 1'b1;
                    end else begin
                        if (right_reg != 8'hFF && first_reg < right_reg)
                            stop_reg <= stop_reg + 7'd1;
                        swap_phase_reg <= 1'b0;
                        state_reg <= S_POP;
                    end
                end
                S_EREAD: state_reg <= S_EKEY;
                S_EKEY: state_reg <= S_EOUT;
                S_EOUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid <= 1'b1;
                        m_index <= ord_rd;
                        m_key   <= key_rd;
                        m_last  <= k_reg == n_reg - 7'd1;
                        if (k_reg == n_reg - 7'd1) begin
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg <= k_reg + 7'd1;
                            state_reg <= S_EREAD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (m_valid && m_ready && state_reg != S_EOUT) m_valid <= 1'b0;
        end
    end

    // Hold the order entries and the left key needed by compare and swap.
    always_ff @(posedge aclk) begin
        if (state_reg == S_RSCAN && swap_phase_reg) kl_reg <= key_rd;
        if (state_reg == S_SWAP && !swap_phase_reg) ol_reg <= ord_rd;
        if (state_reg == S_RKEY) or_reg <= ord_rd;
    end
endmodule

/* rtl/ssw_checker.sv */
// Port checker for the shortest-word sorter, bound to the top level.
`include "assert_macros.svh"
module ssw_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    `ASSERT_IMPLIES(key_range, aclk, aresetn, m_tvalid, m_tdata[14:6] <= 9'd256)
    `ASSERT_IMPLIES(no_load_while_out, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)
    `ASSERT_NEXT(hold_out, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind sort_strings_by_shortest_word_unit ssw_port_checker u_chk (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);

/* dv/ssw_checker.sv */
// Checker that predicts the sorted index stream of the shortest-word sorter.
`timescale 1ns / 1ps
module ssw_checker #(
    parameter int MAX_STRINGS = 64,
    parameter int MAX_CHARS   = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count,
    output int          result_count,
    output int          sort_count
);
    typedef struct {
        logic [5:0] idx;
        logic [8:0] key;
        logic       last;
    } ranked_t;

    ranked_t   ranked_q[$];
    logic [8:0] keys[MAX_STRINGS];
    int        n_strings;
    int        cur_len;
    int        shortest;
    bit        in_word;
    int        n_chars;

    // Close the current string and store its key if there is room.
    task automatic close_string();
        if (in_word && cur_len < shortest) shortest = cur_len;
        if (n_strings < MAX_STRINGS) begin
            keys[n_strings] = shortest[8:0];
            n_strings++;
        end
        cur_len = 0;
        shortest = int'(ssw_pkg::EMPTY_KEY);
        in_word = 0;
        n_chars = 0;
    endtask

    // Hoare quicksort with middle pivot and an explicit range stack.
    task automatic rank_strings(int n);
        int ord[MAX_STRINGS];
        int lo_s[$];
        int hi_s[$];
        int first, last, left, right, t;
        logic [8:0] pivot;
        for (int i = 0; i < n; i++) ord[i] = i;
        if (n > 1) begin
            lo_s.push_back(0);
            hi_s.push_back(n - 1);
        end
        while (lo_s.size() > 0) begin
            first = lo_s.pop_back();
            last = hi_s.pop_back();
            left = first;
            right = last;
            pivot = keys[ord[(left + right) / 2]];
            do begin
                while (left < last && keys[ord[left]] < pivot) left++;
                while (right > first && keys[ord[right]] > pivot) right--;
                if (left <= right) begin
                    t = ord[left];
                    ord[left] = ord[right];
                    ord[right] = t;
                    left++;
                    right--;
                end
            end while (left < right);
            if (left < last) begin
                lo_s.push_back(left);
                hi_s.push_back(last);
            end
            if (first < right) begin
                lo_s.push_back(first);
                hi_s.push_back(right);
            end
        end
        for (int k = 0; k < n; k++)
            ranked_q.push_back('{ord[k][5:0], keys[ord[k]], k == n - 1});
    endtask

    // Predict on accepted requests and compare accepted results.
    always @(posedge aclk) begin
        ranked_t    exp_r;
        logic [7:0] b;
        if (!aresetn) begin
            n_strings = 0;
            cur_len = 0;
            shortest = int'(ssw_pkg::EMPTY_KEY);
            in_word = 0;
            n_chars = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_count++;
                if (ranked_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result idx=%0d key=%0d last=%0b",
                                 m_tdata[5:0], m_tdata[14:6], m_tlast);
                end else begin
                    exp_r = ranked_q.pop_front();
                    if (m_tdata[5:0] !== exp_r.idx || m_tdata[14:6] !== exp_r.key ||
                        m_tdata[15] !== 1'b0 || m_tlast !== exp_r.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display(
                        "mismatch: exp idx=%0d key=%0d last=%0b got idx=%0d key=%0d last=%0b",
                                     exp_r.idx, exp_r.key, exp_r.last,
                                     m_tdata[5:0], m_tdata[14:6], m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                b = s_tdata;
                if (s_tuser[0] && b != ssw_pkg::NUL_CHAR && n_chars < MAX_CHARS) begin
                    n_chars++;
                    if (b == ssw_pkg::SPACE_CHAR) begin
                        if (cur_len < shortest) shortest = cur_len;
                        cur_len = 0;
                        in_word = 0;
                    end else begin
                        if (cur_len < 255) cur_len++;
                        in_word = 1;
                    end
                end
                if (s_tuser[1] || s_tuser[2]) close_string();
                if (s_tuser[2]) begin
                    sort_count++;
                    rank_strings(n_strings);
                    n_strings = 0;
                end
            end
        end
        pending_count = ranked_q.size();
    end

    initial begin
        fail_count = 0;
        pending_count = 0;
        result_count = 0;
        sort_count = 0;
    end
endmodule

/* dv/sort_strings_by_shortest_word_unit_tb.sv */
// Testbench top: drives byte strings into the sorter and gives the verdict.
`timescale 1ns / 1ps
module sort_strings_by_shortest_word_unit_tb;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic [2:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    int          fail_count, pending_count, result_count, sort_count;
    int          idle_cycles = 0;
    int          req_count = 0;
    bit          no_gaps = 0;
    bit          hold_sink = 0;
    bit          s_taken = 0;

    typedef struct {
        logic [7:0] b;
        logic [2:0] u;
    } byte_req_t;
    byte_req_t req_q[$];

    always #6 aclk = ~aclk;

    sort_strings_by_shortest_word_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    ssw_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count), .sort_count(sort_count)
    );

    // Queue one request: byte, present, string end, set end.
    task automatic put(logic [7:0] b, bit p, bit se, bit st);
        req_q.push_back('{b, {st, se, p}});
    endtask

    // A random character: mostly letters, often spaces, sometimes anything.
    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 8'h20;
        if (r < 8) return 8'(8'h61 + $urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one string of random words; the last byte may carry the ends.
    task automatic put_string(int len, bit st);
        if (len == 0) begin
            put(8'($urandom_range(0, 255)), 0, 1, st);
        end else begin
            for (int i = 0; i < len - 1; i++) put(rand_char(), 1, 0, 0);
            put(rand_char(), 1, bit'($urandom_range(0, 1)) | !st, st);
        end
    endtask

    // Note the input handshake at the rising edge.
    always @(posedge aclk) s_taken <= aresetn && s_tvalid && s_tready;

    // Sender: presents queued requests, idles at random.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_taken) begin
                void'(req_q.pop_front());
                req_count++;
            end
            if (!s_tvalid || s_taken) begin
                if (req_q.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 32)) begin
                    s_tvalid <= 1;
                    s_tdata <= req_q[0].b;
                    s_tuser <= req_q[0].u;
                end else begin
                    s_tvalid <= 0;
                end
            end else begin
                s_tvalid <= 1;
            end
        end
    end

    // Receiver: random back-pressure, or a long hold-off when asked.
    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= !hold_sink && (no_gaps || $urandom_range(0, 99) >= 32);
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 100000) begin
            $display("FAIL sort_strings_by_shortest_word_unit");
            $finish;
        end
    end

    task automatic drain();
        wait (req_q.size() == 0 && !s_tvalid);
        wait (pending_count == 0);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        int n, target;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: a lone empty string, leading and doubled spaces, trailing space,
        // NUL and absent bytes, empty strings, equal keys, both ends at once.
        put(8'h00, 0, 0, 1);
        put(8'h20, 1, 0, 0); put(8'h61, 1, 1, 0);
        put(8'h61, 1, 0, 0); put(8'h20, 1, 0, 0); put(8'h20, 1, 0, 0);
        put(8'h62, 1, 1, 0);
        put(8'h61, 1, 0, 0); put(8'h62, 1, 0, 0); put(8'h20, 1, 1, 0);
        put(8'hFF, 0, 1, 0);
        put(8'h00, 1, 0, 0); put(8'h7A, 0, 0, 0); put(8'h00, 1, 1, 0);
        put(8'h63, 1, 0, 0); put(8'h64, 1, 1, 0);
        put(8'hFF, 1, 0, 0); put(8'h80, 1, 1, 1);
        drain();

        // Long string without gaps: more than MAX_CHARS characters, one long word.
        no_gaps = 1;
        for (int i = 0; i < 257; i++) put(8'(8'h41 + i % 20), 1, 0, 0);
        put(8'h00, 0, 1, 0);
        put(8'h78, 1, 1, 1);
        drain();
        no_gaps = 0;

        // Overfull set with receiver hold-off so the block backs up.
        for (int s = 0; s < 66; s++) put_string($urandom_range(0, 1), 0);
        put_string(1, 1);
        put_string(2, 0); put_string(1, 1);
        fork
            begin
                hold_sink = 1;
                repeat (6000) @(posedge aclk);
                hold_sink = 0;
            end
        join_none
        drain();

        // Random sets, with a stretch without gaps in the middle.
        target = req_count + 60;
        while (req_count < target) begin
            no_gaps = (req_count > target - 45 && req_count < target - 20);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
            for (int s = 0; s < n; s++)
                put_string($urandom_range(0, 5), s == n - 1);
            if ($urandom_range(0, 4) == 0)
                put(8'($urandom_range(0, 255)), bit'($urandom_range(0, 1)), 0, 0);
            drain();
        end
        no_gaps = 0;

        $display("Covered %0d requests and %0d sorted sets, %0d results checked.",
                 req_count, sort_count, result_count);
        if (fail_count == 0)
            $display("PASS sort_strings_by_shortest_word_unit");
        else
            $display("FAIL sort_strings_by_shortest_word_unit");
        $finish;
    end
endmodule
